FILE: rtl/core/skf_pkg.sv
// shared constants and controller/datapath interface types for the scalar kalman filter
package skf_pkg;

    localparam int unsigned DATA_W    = 32;
    localparam int unsigned KIND_W    = 2;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned GAIN_W    = 17;
    localparam int unsigned DIV_CNT_W = 5;

    localparam logic [KIND_W-1:0] KIND_PREDICT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_UPDATE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RESET   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MEAS_VARIANCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PROC_VARIANCE = 2'd1;

    localparam logic [DATA_W-1:0] MEAS_VARIANCE_RESET = 32'd65536;
    localparam logic [DATA_W-1:0] PROC_VARIANCE_RESET = 32'd6554;
    localparam logic [DATA_W-1:0] ONE_Q16             = 32'd65536;
    localparam logic [GAIN_W-1:0] GAIN_ONE            = 17'h10000;

    // last quotient step of the gain divider
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = 5'(GAIN_W - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SIMPLE,
        S_DIV,
        S_MUL_E,
        S_MUL_P,
        S_FIN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic simple;
        logic div_step;
        logic mul_e;
        logic mul_p;
        logic fin;
        logic publish;
    } t_dp_cmd;

    typedef struct packed {
        logic div_last;
    } t_dp_sts;

endpackage

FILE: rtl/core/scalar_kalman_filter.sv
// top level of the scalar kalman filter: controller, datapath and checks
//
//  channel | direction | handshake                   | payload
//  --------+-----------+-----------------------------+------------------------------------
//  in      | to block  | i_in_valid / o_in_stall     | i_kind, i_value
//  out     | from block| o_out_valid / i_out_stall   | o_estimate, o_variance, o_overflow
//  cfg     | to block  | i_cfg_valid / o_cfg_ready   | i_cfg_index, i_cfg_data
//
// predict, reset and the unused kind pass through load, the simple step and publish; update
// passes through load, the 17-step gain divider, the two multiplies, the variance write-back
// and the publish step.
// one transaction is worked on at a time; the next is taken once the result is registered.
// a stalled output holds in its register, the block can finish one more item behind it.
// reset (synchronous, active low) clears the estimate to 0, the variance to 1.0 and the
// registers to their defaults; config writes are always ready.
module scalar_kalman_filter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [skf_pkg::KIND_W-1:0]    i_kind,
    input  logic signed [skf_pkg::DATA_W-1:0] i_value,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [skf_pkg::DATA_W-1:0] o_estimate,
    output logic [skf_pkg::DATA_W-1:0]    o_variance,
    output logic                          o_overflow,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [skf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [skf_pkg::DATA_W-1:0]    i_cfg_data
);

    skf_pkg::t_dp_cmd cmd;
    skf_pkg::t_dp_sts sts;
    logic             in_accept;

    assign o_cfg_ready = 1'b1;
    assign in_accept   = i_in_valid && !o_in_stall;

    skf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_kind      (i_kind),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    skf_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_kind      (i_kind),
        .i_value     (i_value),
        .i_cfg_wr    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_estimate  (o_estimate),
        .o_variance  (o_variance),
        .o_overflow  (o_overflow)
    );

    // an accepted transaction keeps the input side busy next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> o_in_stall)
        else $error("input not stalled after accept");

    // a published result is shown and the block is free again
    a_publish_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.publish |=> (o_out_valid && !o_in_stall))
        else $error("published result not presented");

    // the divider hands over to the estimate multiply on its last step
    a_div_to_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.div_step && sts.div_last) |=> cmd.mul_e)
        else $error("divider did not hand over to multiply");

endmodule

FILE: rtl/core/skf_ctrl.sv
// sequencing state machine and handshake control for the scalar kalman filter
module skf_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic [skf_pkg::KIND_W-1:0]    i_kind,
    input  logic                          i_out_stall,
    input  skf_pkg::t_dp_sts              i_sts,
    output logic                          o_in_stall,
    output logic                          o_out_valid,
    output skf_pkg::t_dp_cmd              o_cmd
);

    skf_pkg::t_state r_state;
    skf_pkg::t_state n_state;
    logic            r_out_valid;
    logic            n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= skf_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            skf_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = (i_kind == skf_pkg::KIND_UPDATE) ? skf_pkg::S_DIV
                                                                 : skf_pkg::S_SIMPLE;
                end
            end
            skf_pkg::S_SIMPLE: begin
                o_cmd.simple = 1'b1;
                n_state      = skf_pkg::S_DONE;
            end
            skf_pkg::S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = skf_pkg::S_MUL_E;
                end
            end
            skf_pkg::S_MUL_E: begin
                o_cmd.mul_e = 1'b1;
                n_state     = skf_pkg::S_MUL_P;
            end
            skf_pkg::S_MUL_P: begin
                o_cmd.mul_p = 1'b1;
                n_state     = skf_pkg::S_FIN;
            end
            skf_pkg::S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = skf_pkg::S_DONE;
            end
            skf_pkg::S_DONE: begin
                // wait for the output register to free up
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.publish = 1'b1;
                    n_state       = skf_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = skf_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid && i_out_stall;
        if (o_cmd.publish) begin
            n_out_valid = 1'b1;
        end
    end

    assign o_in_stall  = (r_state != skf_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

FILE: rtl/core/skf_dp.sv
// datapath of the scalar kalman filter: state, config, gain divider, multipliers, output register
module skf_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [skf_pkg::KIND_W-1:0]    i_kind,
    input  logic signed [skf_pkg::DATA_W-1:0] i_value,
    input  logic                          i_cfg_wr,
    input  logic [skf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [skf_pkg::DATA_W-1:0]    i_cfg_data,
    input  skf_pkg::t_dp_cmd              i_cmd,
    output skf_pkg::t_dp_sts              o_sts,
    output logic signed [skf_pkg::DATA_W-1:0] o_estimate,
    output logic [skf_pkg::DATA_W-1:0]    o_variance,
    output logic                          o_overflow
);

    localparam int unsigned W = skf_pkg::DATA_W;
    localparam int unsigned G = skf_pkg::GAIN_W;

    logic [W-1:0]              r_meas;
    logic [W-1:0]              r_proc;
    logic signed [W-1:0]       r_est;
    logic [W-1:0]              r_var;
    logic [skf_pkg::KIND_W-1:0] r_kind;
    logic signed [W-1:0]       r_value;
    logic                      r_ovf;
    logic [W:0]                r_rem;
    logic [W:0]                r_den;
    logic [G-1:0]              r_quo;
    logic [skf_pkg::DIV_CNT_W-1:0] r_cnt;
    logic signed [W+G:0]       r_prod_e;
    logic [W+G-1:0]            r_prod_p;
    logic signed [W-1:0]       r_o_est;
    logic [W-1:0]              r_o_var;
    logic                      r_o_ovf;

    logic signed [W:0]         est_sum;
    logic [W:0]                var_sum;
    logic                      est_sat;
    logic signed [W-1:0]       est_pred;
    logic [W+1:0]              div_t;
    logic                      div_ge;
    logic [G-1:0]              gain;
    logic signed [W:0]         diff;
    logic signed [W+G:0]       prod_e;
    logic [W+G-1:0]            prod_p;
    logic signed [W-1:0]       est_step;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_meas <= skf_pkg::MEAS_VARIANCE_RESET;
            r_proc <= skf_pkg::PROC_VARIANCE_RESET;
        end else if (i_cfg_wr) begin
            unique case (i_cfg_index)
                skf_pkg::CFG_MEAS_VARIANCE: r_meas <= i_cfg_data;
                skf_pkg::CFG_PROC_VARIANCE: r_proc <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // predict arithmetic with saturation
    assign est_sum  = {r_est[W-1], r_est} + {r_value[W-1], r_value};
    assign var_sum  = {1'b0, r_var} + {1'b0, r_proc};
    assign est_sat  = (est_sum[W] != est_sum[W-1]);
    assign est_pred = !est_sat ? est_sum[W-1:0]
                    : (est_sum[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}});

    // restoring divider, first step compares the remainder without a shift
    assign div_t  = (r_cnt == '0) ? {1'b0, r_rem} : {r_rem, 1'b0};
    assign div_ge = (div_t >= {1'b0, r_den});

    // zero denominator gives zero gain
    assign gain     = (r_den == '0) ? '0 : r_quo;
    assign diff     = {r_value[W-1], r_value} - {r_est[W-1], r_est};
    // two's complement product kept to its full width, the magnitude stays below 2^48
    assign prod_e   = {{G{diff[W]}}, diff} * {{(W+1){1'b0}}, gain};
    assign prod_p   = {{G{1'b0}}, r_var} * {{W{1'b0}}, skf_pkg::GAIN_ONE - gain};
    assign est_step = W'(r_prod_e >>> 16);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_est <= '0;
            r_var <= skf_pkg::ONE_Q16;
        end else if (i_cmd.simple) begin
            unique case (r_kind)
                skf_pkg::KIND_PREDICT: begin
                    r_est <= est_pred;
                    r_var <= var_sum[W] ? {W{1'b1}} : var_sum[W-1:0];
                end
                skf_pkg::KIND_RESET: begin
                    r_est <= r_value;
                    r_var <= skf_pkg::ONE_Q16;
                end
                default: ;
            endcase
        end else if (i_cmd.mul_p) begin
            r_est <= r_est + est_step;
        end else if (i_cmd.fin) begin
            r_var <= r_prod_p[W+15:16];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind  <= i_kind;
            r_value <= i_value;
            r_ovf   <= 1'b0;
            r_rem   <= {1'b0, r_var};
            r_den   <= {1'b0, r_var} + {1'b0, r_meas};
            r_quo   <= '0;
            r_cnt   <= '0;
        end else begin
            if (i_cmd.simple && r_kind == skf_pkg::KIND_PREDICT) begin
                r_ovf <= est_sat || var_sum[W];
            end
            if (i_cmd.div_step) begin
                r_rem <= div_ge ? (W+1)'(div_t - {1'b0, r_den}) : div_t[W:0];
                r_quo <= {r_quo[G-2:0], div_ge};
                r_cnt <= r_cnt + 1'b1;
            end
        end
        if (i_cmd.mul_e) begin
            r_prod_e <= prod_e;
        end
        if (i_cmd.mul_p) begin
            r_prod_p <= prod_p;
        end
        if (i_cmd.publish) begin
            r_o_est <= r_est;
            r_o_var <= r_var;
            r_o_ovf <= r_ovf;
        end
    end

    assign o_sts.div_last = (r_cnt == skf_pkg::DIV_LAST);
    assign o_estimate     = r_o_est;
    assign o_variance     = r_o_var;
    assign o_overflow     = r_o_ovf;

endmodule

FILE: tb/skf_checker.sv
// checker for the scalar kalman filter: tracks the filter state, predicts every result and compares
module skf_checker
    import skf_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    input  logic                     i_in_stall,
    input  logic [KIND_W-1:0]        i_kind,
    input  logic signed [DATA_W-1:0] i_value,
    input  logic                     i_out_valid,
    input  logic                     i_out_stall,
    input  logic signed [DATA_W-1:0] i_estimate,
    input  logic [DATA_W-1:0]        i_variance,
    input  logic                     i_overflow,
    input  logic                     i_cfg_valid,
    input  logic                     i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [DATA_W-1:0]        i_cfg_data,
    output int                       o_mismatches,
    output int                       o_outstanding,
    output int                       o_checked,
    output int                       o_overflows,
    output int                       o_updates
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint EST_MAX = 64'sh7FFF_FFFF;
    localparam longint EST_MIN = -64'sh8000_0000;
    localparam longint unsigned VAR_MAX = 64'hFFFF_FFFF;

    typedef struct {
        logic signed [DATA_W-1:0] estimate;
        logic [DATA_W-1:0]        variance;
        logic                     overflow;
    } t_filter_out;

    t_filter_out pending_outputs[$];

    logic signed [DATA_W-1:0] est_track;
    logic [DATA_W-1:0]        var_track;
    logic [DATA_W-1:0]        meas_var_reg;
    logic [DATA_W-1:0]        proc_var_reg;

    // one filter step on the tracked state, returns the result the block must produce
    task automatic advance_filter(input logic [KIND_W-1:0] kind,
                                  input logic signed [DATA_W-1:0] value,
                                  output t_filter_out res);
        longint          e_sum;
        longint          diff;
        longint          step;
        longint unsigned p_sum;
        longint unsigned den;
        longint unsigned gain;
        logic            ovf;
        ovf = 1'b0;
        case (kind)
            KIND_PREDICT: begin
                e_sum = longint'(est_track) + longint'(value);
                p_sum = 64'(var_track) + 64'(proc_var_reg);
                if (e_sum > EST_MAX) begin
                    e_sum = EST_MAX;
                    ovf = 1'b1;
                end else if (e_sum < EST_MIN) begin
                    e_sum = EST_MIN;
                    ovf = 1'b1;
                end
                if (p_sum > VAR_MAX) begin
                    p_sum = VAR_MAX;
                    ovf = 1'b1;
                end
                est_track = DATA_W'(e_sum);
                var_track = DATA_W'(p_sum);
            end
            KIND_UPDATE: begin
                den = 64'(var_track) + 64'(meas_var_reg);
                gain = 64'd0;
                // zero denominator leaves the gain at zero
                if (den != 64'd0) gain = (64'(var_track) << 16) / den;
                if (gain > 64'(ONE_Q16)) gain = 64'(ONE_Q16);
                diff = longint'(value) - longint'(est_track);
                // arithmetic shift of the signed product rounds toward minus infinity
                step = (diff * longint'(gain)) >>> 16;
                est_track = DATA_W'(longint'(est_track) + step);
                var_track = DATA_W'((64'(var_track) * (64'(ONE_Q16) - gain)) >> 16);
                o_updates++;
            end
            KIND_RESET: begin
                est_track = value;
                var_track = ONE_Q16;
            end
            default: ;
        endcase
        res.estimate = est_track;
        res.variance = var_track;
        res.overflow = ovf;
    endtask

    initial begin
        o_mismatches  = 0;
        o_outstanding = 0;
        o_checked     = 0;
        o_overflows   = 0;
        o_updates     = 0;
    end

    always @(posedge i_clk) begin
        t_filter_out exp_out;
        if (!i_rst_n) begin
            est_track    = '0;
            var_track    = ONE_Q16;
            meas_var_reg = MEAS_VARIANCE_RESET;
            proc_var_reg = PROC_VARIANCE_RESET;
            pending_outputs.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (pending_outputs.size() == 0) begin
                    $display("%0t: result with no transaction waiting, expected none, actual %h %h %b",
                             $time, i_estimate, i_variance, i_overflow);
                    o_mismatches++;
                end else begin
                    exp_out = pending_outputs.pop_front();
                    if (i_estimate !== exp_out.estimate) begin
                        $display("%0t: estimate mismatch, expected %h actual %h",
                                 $time, exp_out.estimate, i_estimate);
                        o_mismatches++;
                    end
                    if (i_variance !== exp_out.variance) begin
                        $display("%0t: variance mismatch, expected %h actual %h",
                                 $time, exp_out.variance, i_variance);
                        o_mismatches++;
                    end
                    if (i_overflow !== exp_out.overflow) begin
                        $display("%0t: overflow mismatch, expected %b actual %b",
                                 $time, exp_out.overflow, i_overflow);
                        o_mismatches++;
                    end
                    o_checked++;
                    if (exp_out.overflow) o_overflows++;
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_MEAS_VARIANCE: meas_var_reg = i_cfg_data;
                    CFG_PROC_VARIANCE: proc_var_reg = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                advance_filter(i_kind, i_value, exp_out);
                pending_outputs.push_back(exp_out);
            end
        end
        o_outstanding = pending_outputs.size();
    end

endmodule

FILE: tb/tb_scalar_kalman_filter.sv
// testbench top for the scalar kalman filter: stimulus, output stall pattern and verdict
module tb_scalar_kalman_filter;
    timeunit 1ns;
    timeprecision 1ps;

    import skf_pkg::*;

    localparam logic [KIND_W-1:0]    KIND_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
    localparam int DRAIN_CYCLES    = 30;
    localparam int RANDOM_PHASES   = 6;
    localparam int ITEMS_PER_PHASE = 96;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     in_valid;
    logic                     in_stall;
    logic [KIND_W-1:0]        in_kind;
    logic signed [DATA_W-1:0] in_value;
    logic                     out_valid;
    logic                     out_stall;
    logic signed [DATA_W-1:0] out_estimate;
    logic [DATA_W-1:0]        out_variance;
    logic                     out_overflow;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [DATA_W-1:0]        cfg_data;

    int mismatches;
    int outstanding;
    int checked;
    int overflows;
    int updates;
    int cfg_writes;

    scalar_kalman_filter dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_kind      (in_kind),
        .i_value     (in_value),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_estimate  (out_estimate),
        .o_variance  (out_variance),
        .o_overflow  (out_overflow),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    skf_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_kind        (in_kind),
        .i_value       (in_value),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_estimate    (out_estimate),
        .i_variance    (out_variance),
        .i_overflow    (out_overflow),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding),
        .o_checked     (checked),
        .o_overflows   (overflows),
        .o_updates     (updates)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

    // output stall pattern: free running, sparse, heavy and long runs, switched at random
    initial begin
        int   mode;
        int   left;
        int   run;
        logic level;
        out_stall = 1'b0;
        forever begin
            mode  = $urandom_range(0, 3);
            left  = $urandom_range(20, 300);
            run   = 0;
            level = 1'b0;
            repeat (left) begin
                @(negedge i_clk);
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    2: out_stall <= 1'($urandom_range(0, 1));
                    default: begin
                        if (run == 0) begin
                            level = ~level;
                            run   = $urandom_range(1, 30);
                        end
                        run--;
                        out_stall <= level;
                    end
                endcase
            end
        end
    end

    task automatic send_item(input logic [KIND_W-1:0] kind, input logic signed [DATA_W-1:0] value);
        @(negedge i_clk);
        in_valid <= 1'b1;
        in_kind  <= kind;
        in_value <= value;
        do @(posedge i_clk); while (in_stall);
    endtask

    task automatic pause_sender(input int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            in_valid <= 1'b0;
        end
    endtask

    // stop sending and wait until every result has come back, then let the block settle
    task automatic drain_block();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do @(posedge i_clk); while (!cfg_ready);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
        cfg_writes++;
    endtask

    function automatic logic signed [DATA_W-1:0] rand_q16();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return int'($urandom_range(0, 1 << 21)) - (1 << 20);
            2: return int'($urandom_range(0, 1 << 25)) - (1 << 24);
            default: begin
                case ($urandom_range(0, 3))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
        endcase
    endfunction

    initial begin
        logic [DATA_W-1:0] r_set;
        logic [DATA_W-1:0] q_set;
        logic [KIND_W-1:0] kind;
        int                pick;
        int                burst_left;
        in_valid   = 1'b0;
        in_kind    = KIND_PREDICT;
        in_value   = '0;
        cfg_valid  = 1'b0;
        cfg_index  = CFG_MEAS_VARIANCE;
        cfg_data   = '0;
        cfg_writes = 0;
        i_rst_n    = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // default registers: saturation both ways, extreme measurements, unused kind
        send_item(KIND_UPDATE,  32'h0000_0000);
        send_item(KIND_RESET,   32'h7FFF_FFFF);
        send_item(KIND_PREDICT, 32'h0000_0001);
        send_item(KIND_PREDICT, 32'h8000_0000);
        send_item(KIND_RESET,   32'h8000_0000);
        send_item(KIND_PREDICT, 32'hFFFF_FFFF);
        send_item(KIND_UPDATE,  32'h7FFF_FFFF);
        send_item(KIND_UPDATE,  32'h8000_0000);
        send_item(KIND_UNUSED,  32'h5A5A_A5A5);
        send_item(KIND_RESET,   32'h0000_0000);
        send_item(KIND_PREDICT, 32'h0001_0000);

        // zero measurement variance gives a unit gain, then zero denominator
        drain_block();
        write_reg(CFG_MEAS_VARIANCE, 32'h0000_0000);
        write_reg(CFG_PROC_VARIANCE, 32'h0000_0000);
        send_item(KIND_RESET,   32'h0005_0000);
        send_item(KIND_UPDATE,  32'h0064_0000);
        send_item(KIND_UPDATE,  32'hFFF9_0000);
        send_item(KIND_PREDICT, 32'h0003_0000);
        send_item(KIND_UNUSED,  32'hA5A5_5A5A);

        // largest registers: variance clamps on the second predict
        drain_block();
        write_reg(CFG_MEAS_VARIANCE, 32'hFFFF_FFFF);
        write_reg(CFG_PROC_VARIANCE, 32'hFFFF_FFFF);
        send_item(KIND_PREDICT, 32'h0000_0000);
        send_item(KIND_PREDICT, 32'h0000_0000);
        send_item(KIND_UPDATE,  32'h7FFF_FFFF);
        send_item(KIND_UPDATE,  32'h8000_0000);

        // writes to unmapped indexes must not disturb anything
        drain_block();
        write_reg(CFG_SPARE_A, 32'hDEAD_BEEF);
        write_reg(CFG_SPARE_B, 32'h0000_0001);
        send_item(KIND_RESET,   32'h1234_5678);
        send_item(KIND_PREDICT, 32'hFFFF_0000);
        send_item(KIND_UPDATE,  32'h0000_0000);

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            drain_block();
            case (phase)
                0: begin
                    r_set = 32'h0000_0001;
                    q_set = 32'h0000_0000;
                end
                1: begin
                    r_set = $urandom;
                    q_set = $urandom_range(0, 1 << 16);
                end
                2: begin
                    r_set = 32'hFFFF_FFFF;
                    q_set = 32'hFFFF_FFFF;
                end
                3: begin
                    r_set = 32'h0000_0000;
                    q_set = $urandom_range(1, 1 << 20);
                end
                4: begin
                    r_set = $urandom_range(1, 1 << 18);
                    q_set = $urandom;
                end
                default: begin
                    r_set = MEAS_VARIANCE_RESET;
                    q_set = PROC_VARIANCE_RESET;
                end
            endcase
            write_reg(CFG_MEAS_VARIANCE, r_set);
            write_reg(CFG_PROC_VARIANCE, q_set);
            burst_left = 0;
            repeat (ITEMS_PER_PHASE) begin
                if (burst_left == 0) begin
                    pause_sender($urandom_range(1, 12));
                    burst_left = $urandom_range(1, 30);
                end else if ($urandom_range(0, 59) == 0) begin
                    drain_block();
                end
                pick = $urandom_range(0, 99);
                if (pick < 45)      kind = KIND_PREDICT;
                else if (pick < 85) kind = KIND_UPDATE;
                else if (pick < 96) kind = KIND_RESET;
                else                kind = KIND_UNUSED;
                send_item(kind, rand_q16());
                burst_left--;
            end
        end

        drain_block();
        $display("checked %0d results (%0d updates, %0d with overflow) over %0d register writes",
                 checked, updates, overflows, cfg_writes);
        if (mismatches == 0 && outstanding == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/skf_pkg.sv
rtl/core/skf_ctrl.sv
rtl/core/skf_dp.sv
rtl/core/scalar_kalman_filter.sv
tb/skf_checker.sv
tb/tb_scalar_kalman_filter.sv
